@@ design/ordered_list_store_assert.svh @@
// assertion macros for the ordered list store rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef ORDERED_LIST_STORE_ASSERT_SVH
`define ORDERED_LIST_STORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define OLS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list store assertion failed");

// consequent must hold in the cycle after the antecedent
`define OLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list store assertion failed");

`endif

@@ design/ols_pkg.sv @@
// shared widths, operation and status codes and command types
// for the ordered list store; no dependencies
`default_nettype none

package ols_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELETE   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch operation and compare against all cells
        logic execute;  // apply operation and load result registers
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ design/ols_datapath.sv @@
// list cells, per-cell compare, shift network and result registers
// depends on ols_pkg
`default_nettype none

module ols_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire ols_pkg::dp_cmd_t         cmd,
    input  wire [ols_pkg::FUNC_W-1:0]     func,
    input  wire signed [ols_pkg::VALUE_W-1:0] value,
    output logic [ols_pkg::STATUS_W-1:0]  status,
    output logic                          found,
    output logic [ols_pkg::COUNT_W-1:0]   count
);
    import ols_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [FUNC_W-1:0]   func_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CAPACITY-1:0] match_reg;
    logic [VALUE_W-1:0]  list_reg  [CAPACITY];
    logic [VALUE_W-1:0]  list_next [CAPACITY];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                found_reg;
    logic                found_next;
    logic [COUNT_W-1:0]  count_out_reg;

    logic                full;
    logic                empty;
    logic                hit;
    logic [CAPACITY-1:0] first_hit;
    logic [CAPACITY-1:0] at_or_after;

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);
    assign hit   = |match_reg;

    // lowest matching cell, then every cell from there upwards
    assign first_hit   = match_reg & (~match_reg + 1'b1);
    assign at_or_after = ~(first_hit - 1'b1);

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            list_next[i] = list_reg[i];
        end
        count_next  = count_reg;
        status_next = ST_OK;
        found_next  = 1'b0;
        unique case (func_reg)
            FUNC_INS_TAIL:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    list_next[count_reg[IW-1:0]] = value_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_INS_HEAD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    list_next[0] = value_reg;
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        list_next[i] = list_reg[i-1];
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            FUNC_SEARCH:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (hit)
                begin
                    found_next = 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            FUNC_DELETE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (hit)
                begin
                    found_next = 1'b1;
                    // close the gap from the first match upwards
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        if (at_or_after[i])
                        begin
                            list_next[i] = list_reg[i+1];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            value_reg <= value;
            for (int i = 0; i < CAPACITY; i++)
            begin
                match_reg[i] <= (list_reg[i] == value) && (CW'(i) < count_reg);
            end
        end
        if (cmd.execute)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                list_reg[i] <= list_next[i];
            end
            status_reg    <= status_next;
            found_reg     <= found_next;
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign status = status_reg;
    assign found  = found_reg;
    assign count  = count_out_reg;

endmodule

`default_nettype wire

@@ design/ols_controller.sv @@
// sequencing state machine and output valid for the ordered list store
// depends on ols_pkg
`default_nettype none

module ols_controller (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire               out_stall,
    output ols_pkg::dp_cmd_t  cmd
);
    import ols_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    // result register may be loaded when empty or being taken this cycle
    assign out_free    = !out_valid_reg || !out_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign cmd.capture = in_valid && (state_reg == S_IDLE);
    assign cmd.execute = (state_reg == S_EXEC) && out_free;
    assign out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces a taken one in the same cycle
            if ((state_reg == S_EXEC) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/ordered_list_store.sv @@
// top level of the ordered list store: controller, datapath and checks
// depends on ols_pkg, ols_controller, ols_datapath, ordered_list_store_assert.svh
// Ordered list of up to CAPACITY signed 32-bit values held in a row of
// register cells. Each transaction carries an operation (insert at tail,
// insert at head, search, delete first match) and a value, and returns one
// result transaction with status, found flag and the entry count after the
// operation. An insert into a full list is dropped with status full; search
// or delete on an empty list reports empty. In the accept cycle every cell
// compares its entry with the value in parallel; in the execute state the
// first match is picked and the cells shift to their neighbours in one step.
// The result sits in an output register; if it has not been taken the next
// transaction waits in its execute state. The block cannot take a new
// transaction before the last one has executed. in_stall is high whenever a
// transaction is in progress. No clearing pass is needed after reset: only
// entries below the count are ever compared or reported.
`default_nettype none

`include "ordered_list_store_assert.svh"

module ordered_list_store #(
    parameter int CAPACITY = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // request channel
    input  wire                               in_valid,
    output logic                              in_stall,
    input  wire [ols_pkg::FUNC_W-1:0]         func,
    input  wire signed [ols_pkg::VALUE_W-1:0] value,
    // result channel
    output logic                              out_valid,
    input  wire                               out_stall,
    output logic [ols_pkg::STATUS_W-1:0]      status,
    output logic                              found,
    output logic [ols_pkg::COUNT_W-1:0]       count
);
    import ols_pkg::*;

    dp_cmd_t cmd;

    // sequencing: accept, then execute once the result register is free
    ols_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // cells, compare row, shift network and result registers
    ols_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .func   (func),
        .value  (value),
        .status (status),
        .found  (found),
        .count  (count)
    );

    // an accepted transaction keeps the request side busy while it executes
    `OLS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // an empty list reports no match and a zero count
    `OLS_ASSERT_NOW(a_empty_result, out_valid && status == ST_EMPTY, !found && count == '0)
    // a match is always reported with status ok
    `OLS_ASSERT_NOW(a_found_ok, out_valid && found, status == ST_OK)
    // a dropped insert only happens with the list at capacity
    `OLS_ASSERT_NOW(a_full_count, out_valid && status == ST_FULL, count == COUNT_W'(CAPACITY))

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the ordered list store: directed and random list operations
// with a mirrored list per transaction; depends on ols_pkg and the ordered_list_store rtl

module testbench;

    import ols_pkg::*;

    localparam int LIST_CAP     = 16;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 300000;

    // one result transaction as the block reports it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } list_result_t;

    // receiver stall behaviour, chosen afresh when the current mode's run ends
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   func;
    logic [VALUE_W-1:0]  value;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;

    // mirrored list contents, oldest position first
    logic [VALUE_W-1:0] model_list[$];
    // results still owed by the block, in issue order
    list_result_t       pending_results[$];

    int fail_count;
    int cycle_count;
    int hold_request;   // long receiver hold-off asked for by a test, in cycles
    bit sender_gaps;    // sender idles between bursts when set
    int burst_left;

    ordered_list_store #(
        .CAPACITY (LIST_CAP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found     (found),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // list predictor: applies one operation to the mirrored list and
    // returns the status, found flag and count the block should report
    // ------------------------------------------------------------------
    function automatic list_result_t predict_op(input logic [FUNC_W-1:0] op,
                                                input logic [VALUE_W-1:0] v);
        list_result_t res;
        int           pos;
        res.status = ST_OK;
        res.found  = 1'b0;
        pos        = -1;
        case (op)
            FUNC_INS_TAIL, FUNC_INS_HEAD:
            begin
                // a full list drops the insert and stays as it is
                if (model_list.size() >= LIST_CAP)
                begin
                    res.status = ST_FULL;
                end
                else if (op == FUNC_INS_TAIL)
                begin
                    model_list = {model_list, v};
                end
                else
                begin
                    model_list.push_front(v);
                end
            end
            default:
            begin
                if (model_list.size() == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    // lowest position wins, so duplicates go one at a time
                    for (int i = 0; i < model_list.size(); i++)
                    begin
                        if (pos < 0 && model_list[i] == v)
                        begin
                            pos = i;
                        end
                    end
                    if (pos < 0)
                    begin
                        res.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        res.found = 1'b1;
                        if (op == FUNC_DELETE)
                        begin
                            model_list.delete(pos);
                        end
                    end
                end
            end
        endcase
        res.count = COUNT_W'(model_list.size());
        return res;
    endfunction

    // value choice: often an entry already held, so searches and deletes hit,
    // then a small pool that breeds duplicates, the extremes, and pure noise
    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45 && model_list.size() > 0)
        begin
            return model_list[$urandom_range(0, model_list.size() - 1)];
        end
        if (sel < 75)
        begin
            return VALUE_W'(int'($urandom_range(0, 5)) - 3);
        end
        if (sel < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // drop valid and scramble the idle payload for a number of cycles
    task automatic pause_sender(input int n_cycles);
        in_valid <= 1'b0;
        func     <= FUNC_W'($urandom());
        value    <= $urandom();
        repeat (n_cycles) @(posedge clk);
    endtask

    // offer one transaction, hold it until taken, then log its prediction;
    // valid stays high into the next call unless a gap is due
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] v);
        list_result_t expected_res;
        in_valid <= 1'b1;
        func     <= op;
        value    <= v;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        expected_res    = predict_op(op, v);
        pending_results = {pending_results, expected_res};
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                pause_sender($urandom_range(1, 7));
                burst_left = $urandom_range(0, 10);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: own stall pattern plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          hold_left;
        int          phase;
        out_stall = 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
            end
            else
            begin
                mode_left--;
            end
            phase = (phase + 1) % 5;
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                case (mode)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                    default:        out_stall <= (phase < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: every taken result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing outstanding: status %0d found %0d count %0d",
                       status, found, count);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (found !== want.found)
                begin
                    $error("found mismatch: expected %0d, actual %0d", want.found, found);
                    fail_count++;
                end
                if (count !== want.count)
                begin
                    $error("count mismatch: expected %0d, actual %0d", want.count, count);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // search and delete with nothing stored report empty
    task automatic test_empty_list();
        send_op(FUNC_SEARCH, 32'h0000_0000);
        send_op(FUNC_DELETE, 32'h7fff_ffff);
        send_op(FUNC_SEARCH, 32'h8000_0000);
    endtask

    // extreme values at both ends, hits, misses and a delete from the middle
    task automatic test_extreme_values();
        send_op(FUNC_INS_TAIL, 32'h7fff_ffff);
        send_op(FUNC_INS_TAIL, 32'h8000_0000);
        send_op(FUNC_INS_HEAD, 32'h0000_0000);
        send_op(FUNC_INS_HEAD, 32'hffff_ffff);
        send_op(FUNC_SEARCH, 32'h8000_0000);
        send_op(FUNC_SEARCH, 32'h7fff_fffe);
        send_op(FUNC_DELETE, 32'h0000_0000);
        send_op(FUNC_DELETE, 32'h0001_2345);
        send_op(FUNC_SEARCH, 32'h0000_0000);
    endtask

    // duplicates leave one at a time, then the list is emptied out
    task automatic test_duplicates();
        send_op(FUNC_INS_TAIL, 32'd5);
        send_op(FUNC_INS_HEAD, 32'd5);
        send_op(FUNC_INS_TAIL, -32'sd5);
        send_op(FUNC_DELETE, 32'd5);
        send_op(FUNC_SEARCH, 32'd5);
        send_op(FUNC_DELETE, 32'd5);
        send_op(FUNC_SEARCH, 32'd5);
        send_op(FUNC_DELETE, 32'hffff_ffff);
        send_op(FUNC_DELETE, 32'h8000_0000);
        send_op(FUNC_DELETE, 32'h7fff_ffff);
        send_op(FUNC_DELETE, -32'sd5);
        send_op(FUNC_DELETE, 32'd5);
    endtask

    // random operation mix; insert_pct steers the list towards full or empty
    task automatic test_random_mix(input int n_items, input int insert_pct);
        repeat (n_items)
        begin
            if ($urandom_range(0, 99) < insert_pct)
            begin
                send_op($urandom_range(0, 1) ? FUNC_INS_HEAD : FUNC_INS_TAIL, pick_value());
            end
            else
            begin
                send_op($urandom_range(0, 1) ? FUNC_DELETE : FUNC_SEARCH, pick_value());
            end
        end
    endtask

    // fill to capacity, insert into the full list both ways, then drain
    task automatic test_full_list();
        while (model_list.size() < LIST_CAP)
        begin
            send_op($urandom_range(0, 1) ? FUNC_INS_HEAD : FUNC_INS_TAIL, pick_value());
        end
        send_op(FUNC_INS_TAIL, $urandom());
        send_op(FUNC_INS_HEAD, $urandom());
        send_op(FUNC_SEARCH, model_list[LIST_CAP-1]);
        send_op(FUNC_DELETE, ~model_list[0]);
        while (model_list.size() > 0)
        begin
            // mostly real entries from anywhere in the list, the odd miss
            send_op(FUNC_DELETE, ($urandom_range(0, 7) == 0) ? pick_value() :
                    model_list[$urandom_range(0, model_list.size() - 1)]);
        end
        send_op(FUNC_DELETE, pick_value());
    endtask

    // receiver holds off for a long stretch while transactions keep coming,
    // so the output register fills and the block stalls its input
    task automatic test_back_pressure();
        sender_gaps  = 1'b0;
        hold_request = 250;
        test_random_mix(30, 50);
        sender_gaps  = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_INS_TAIL;
        value        = '0;
        fail_count   = 0;
        hold_request = 0;
        sender_gaps  = 1'b1;
        burst_left   = $urandom_range(0, 10);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_extreme_values();
        test_duplicates();

        test_random_mix(150, 60);
        test_full_list();
        test_random_mix(150, 40);
        test_back_pressure();
        test_full_list();
        // a stretch with no sender idling
        sender_gaps = 1'b0;
        test_random_mix(120, 50);
        sender_gaps = 1'b1;
        test_full_list();
        test_random_mix(150, 55);

        pause_sender(1);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** ordered_list_store: PASSED **");
        end
        else
        begin
            $display("** ordered_list_store: FAILED **");
        end
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("run limit of %0d cycles reached", LIMIT_CYCLES);
        $display("** ordered_list_store: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/ols_pkg.sv
design/ols_datapath.sv
design/ols_controller.sv
design/ordered_list_store.sv
dv/testbench.sv
